// ----- hw/rtl/spi_sensor_register_slave_core_macros.svh -----
// Assertion macros used by the checker of the SPI sensor register slave.
`ifndef SPI_SENSOR_REGISTER_SLAVE_CORE_MACROS_SVH
`define SPI_SENSOR_REGISTER_SLAVE_CORE_MACROS_SVH

// Check a property at each rising clock edge, skipped while reset is high.
`define SSRS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ssrs assertion failed");

// Check a property at each rising clock edge, reset included.
`define SSRS_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("ssrs assertion failed");

`endif

// ----- hw/rtl/ssrs_pkg.sv -----
package ssrs_pkg;

   localparam int unsigned TABLE_LEN = 10;

   localparam logic [3:0] POS_LAST = 4'(TABLE_LEN - 1);

   localparam logic [7:0] DEVICE_ID_RESET = 8'hCD;
   localparam logic [7:0] ADDR_DEVICE_ID  = 8'h00;
   localparam logic [7:0] ADDR_TEMP       = 8'h01;
   localparam logic [7:0] ADDR_PRES       = 8'h02;
   localparam logic [7:0] READ_IDLE       = 8'hFF;

   localparam logic [7:0] TEMP_VALUES [16] = '{
      8'd20, 8'd21, 8'd22, 8'd23, 8'd24, 8'd23, 8'd22, 8'd21,
      8'd20, 8'd19, 8'd20, 8'd21, 8'd22, 8'd23, 8'd24, 8'd23
   };

   localparam logic [7:0] PRES_VALUES [16] = '{
      8'd45, 8'd47, 8'd50, 8'd52, 8'd55, 8'd53, 8'd50, 8'd48,
      8'd45, 8'd43, 8'd45, 8'd47, 8'd50, 8'd52, 8'd55, 8'd53
   };

   function automatic logic [7:0] read_register(
      input logic [7:0] addr,
      input logic [3:0] pos,
      input logic [7:0] device_id
   );
      logic [7:0] value;
      unique case (addr)
         ADDR_DEVICE_ID: value = device_id;
         ADDR_TEMP:      value = TEMP_VALUES[pos];
         ADDR_PRES:      value = PRES_VALUES[pos];
         default:        value = READ_IDLE;
      endcase
      return value;
   endfunction

endpackage

// ----- hw/rtl/spi_sensor_register_slave_core.sv -----
// SPI mode-0 register read slave with address auto-increment.
// req_ channel: one transfer per system clock while req_stall is low carries one
// sample of the SPI pins (chip_select_n, serial_clock, mosi); edges are found by
// comparing with the previous accepted sample. rsp_ channel: one transfer per request
// carries the MISO level to drive (1 while not selected).
// csr_ channel: writes device_id, the value read at address zero; it is
// always ready and takes effect for the next request.
// Response: the MISO level of an accepted request is registered in the response
// register, or in the skid register while the response register is held.
// Throughput: one request per cycle while req_stall is low, set by the single state
// update and response register.
// Stall: an accepted request whose response cannot leave goes into a one-entry
// skid register; req_stall rises only while that skid entry is full, so
// nothing is lost or repeated.
// Reset (synchronous, active high): deselected, transmit shifter all ones,
// address zero, sample position zero, device_id 0xCD, both response
// registers empty.
module spi_sensor_register_slave_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_chip_select_n,
   input  logic       req_serial_clock,
   input  logic       req_mosi,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_miso_bit,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_data
);
   import ssrs_pkg::*;

   logic       selected_ff, selected_in;
   logic       last_select_ff;
   logic       last_clock_ff;
   logic [2:0] bits_ff, bits_in;
   logic [7:0] rx_ff, rx_in;
   logic [7:0] tx_ff, tx_in;
   logic       addr_rcvd_ff, addr_rcvd_in;
   logic [7:0] cur_reg_ff, cur_reg_in;
   logic [3:0] pos_ff, pos_in;
   logic [7:0] device_id_ff;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_miso_ff, rsp_miso_in;
   logic skid_valid_ff, skid_valid_in;
   logic skid_miso_ff;

   logic accept;
   logic out_free;
   logic sel_fall, sel_rise, clk_rise, clk_fall;
   logic [7:0] rx_next;
   logic [7:0] tx_mid;
   logic [7:0] next_reg;
   logic miso;

   assign csr_ready = 1'b1;
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign sel_fall = last_select_ff && !req_chip_select_n;
   assign sel_rise = !last_select_ff && req_chip_select_n;

   always_comb begin
      selected_in  = selected_ff;
      bits_in      = bits_ff;
      rx_in        = rx_ff;
      tx_mid       = tx_ff;
      addr_rcvd_in = addr_rcvd_ff;
      cur_reg_in   = cur_reg_ff;
      pos_in       = pos_ff;
      if (sel_fall) begin
         selected_in  = 1'b1;
         bits_in      = '0;
         addr_rcvd_in = 1'b0;
         rx_in        = '0;
         tx_mid       = READ_IDLE;
      end else if (sel_rise) begin
         if (selected_ff) begin
            pos_in = (pos_ff == POS_LAST) ? '0 : pos_ff + 4'd1;
         end
         selected_in = 1'b0;
      end
      tx_in    = tx_mid;
      rx_next  = {rx_in[6:0], req_mosi};
      next_reg = addr_rcvd_in ? cur_reg_ff + 8'd1 : rx_next;
      clk_rise = selected_in && !last_clock_ff && req_serial_clock;
      clk_fall = selected_in && last_clock_ff && !req_serial_clock;
      miso     = selected_in ? tx_ff[7] : 1'b1;
      if (clk_rise) begin
         if (bits_in == 3'd7) begin
            cur_reg_in   = next_reg;
            tx_in        = read_register(next_reg, pos_ff, device_id_ff);
            addr_rcvd_in = 1'b1;
            bits_in      = '0;
            rx_in        = '0;
         end else begin
            rx_in   = rx_next;
            bits_in = bits_in + 3'd1;
         end
      end
      if (clk_fall) begin
         miso  = tx_mid[7];
         tx_in = {tx_mid[6:0], 1'b0};
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_miso_in   = rsp_miso_ff;
      skid_valid_in = skid_valid_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_miso_in   = skid_miso_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = accept;
            rsp_miso_in  = miso;
         end
      end else if (accept) begin
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         selected_ff    <= 1'b0;
         last_select_ff <= 1'b1;
         last_clock_ff  <= 1'b0;
         bits_ff        <= '0;
         rx_ff          <= '0;
         tx_ff          <= READ_IDLE;
         addr_rcvd_ff   <= 1'b0;
         cur_reg_ff     <= '0;
         pos_ff         <= '0;
         device_id_ff   <= DEVICE_ID_RESET;
         rsp_valid_ff   <= 1'b0;
         skid_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            device_id_ff <= csr_data;
         end
         if (accept) begin
            selected_ff    <= selected_in;
            last_select_ff <= req_chip_select_n;
            last_clock_ff  <= req_serial_clock;
            bits_ff        <= bits_in;
            rx_ff          <= rx_in;
            tx_ff          <= tx_in;
            addr_rcvd_ff   <= addr_rcvd_in;
            cur_reg_ff     <= cur_reg_in;
            pos_ff         <= pos_in;
         end
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_miso_ff <= rsp_miso_in;
      if (accept && !out_free) begin
         skid_miso_ff <= miso;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_miso_bit = rsp_miso_ff;

endmodule

// ----- hw/rtl/ssrs_checker.sv -----
`include "spi_sensor_register_slave_core_macros.svh"

module ssrs_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic req_chip_select_n,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_miso_bit
);

   `SSRS_ASSERT(rsp_hold_a, clock, reset,
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_miso_bit))

   `SSRS_ASSERT_ALWAYS(rsp_empty_after_reset_a, clock, !reset && $past(reset) |-> !rsp_valid)

   `SSRS_ASSERT(accept_gives_rsp_a, clock, reset,
      req_valid && !req_stall |=> rsp_valid)

   `SSRS_ASSERT(unselected_reads_one_a, clock, reset,
      req_valid && !req_stall && req_chip_select_n && (!rsp_valid || !rsp_stall)
      |=> rsp_valid && rsp_miso_bit)

   `SSRS_ASSERT(stall_only_when_full_a, clock, reset, req_stall |-> rsp_valid)

endmodule

bind spi_sensor_register_slave_core ssrs_checker u_ssrs_checker (.*);

// ----- tb/tb.sv -----
module tb;
   import ssrs_pkg::*;

   localparam int CYCLE_LIMIT = 150000;
   localparam int LONG_HOLD   = 60;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_chip_select_n = 1'b1;
   logic       req_serial_clock = 1'b0;
   logic       req_mosi = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_miso_bit;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [7:0] csr_data = 8'h00;

   // slave state as seen from the pins
   logic       sel = 1'b0;
   logic       last_cs = 1'b1;
   logic       last_sck = 1'b0;
   logic [2:0] bits_seen = 3'd0;
   logic [7:0] rx_byte = 8'h00;
   logic [7:0] tx_byte = READ_IDLE;
   logic       addr_seen = 1'b0;
   logic [7:0] cur_addr = 8'h00;
   logic [3:0] sample_pos = 4'd0;
   logic [7:0] dev_id = DEVICE_ID_RESET;

   logic       miso_expected[$];
   int         error_count = 0;
   int         items_sent = 0;
   int         cycle_count = 0;
   bit         idle_enable = 1'b1;
   bit         hold_go = 1'b0;

   spi_sensor_register_slave_core u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_chip_select_n (req_chip_select_n),
      .req_serial_clock  (req_serial_clock),
      .req_mosi          (req_mosi),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_miso_bit      (rsp_miso_bit),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_data          (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [7:0] register_value(logic [7:0] addr);
      logic [3:0] pos;
      pos = 4'((int'(sample_pos) % TABLE_LEN) & 15);
      case (addr)
         ADDR_DEVICE_ID: return dev_id;
         ADDR_TEMP:      return TEMP_VALUES[pos];
         ADDR_PRES:      return PRES_VALUES[pos];
         default:        return READ_IDLE;
      endcase
   endfunction

   function automatic logic miso_for_sample(logic cs, logic sck, logic mosi);
      logic miso;
      miso = tx_byte[7];
      if (last_cs && !cs) begin
         sel = 1'b1;
         bits_seen = 3'd0;
         addr_seen = 1'b0;
         rx_byte = 8'h00;
         tx_byte = READ_IDLE;
      end else if (!last_cs && cs) begin
         if (sel) begin
            sample_pos = 4'((int'(sample_pos) + 1) % TABLE_LEN);
         end
         sel = 1'b0;
      end
      last_cs = cs;
      if (!sel) begin
         last_sck = sck;
         return 1'b1;
      end
      if (!last_sck && sck) begin
         rx_byte = {rx_byte[6:0], mosi};
         if (bits_seen == 3'd7) begin
            cur_addr = addr_seen ? cur_addr + 8'd1 : rx_byte;
            tx_byte = register_value(cur_addr);
            addr_seen = 1'b1;
            bits_seen = 3'd0;
            rx_byte = 8'h00;
         end else begin
            bits_seen = bits_seen + 3'd1;
         end
      end
      if (last_sck && !sck) begin
         miso = tx_byte[7];
         tx_byte = {tx_byte[6:0], 1'b0};
      end
      last_sck = sck;
      return miso;
   endfunction

   // one pin sample per transfer
   task automatic pin(input logic cs, input logic sck, input logic mosi);
      if (idle_enable && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_chip_select_n <= cs;
      req_serial_clock <= sck;
      req_mosi <= mosi;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      miso_expected.push_back(miso_for_sample(cs, sck, mosi));
      items_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      wait (miso_expected.size() == 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_device_id(input logic [7:0] value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      dev_id = value;
   endtask

   // mode 0: data set while clock low, sampled on the rising edge
   task automatic send_byte(input logic [7:0] value, input int nbits);
      int i;
      for (i = 0; i < nbits; i++) begin
         repeat ($urandom_range(1, 2)) pin(1'b0, 1'b0, value[7 - i]);
         repeat ($urandom_range(1, 2)) pin(1'b0, 1'b1, value[7 - i]);
      end
   endtask

   // cut_bits below zero: full frame; otherwise deselect inside the last byte
   task automatic spi_frame(input logic [7:0] addr, input int n_bytes, input int cut_bits);
      int b;
      int nbits;
      logic [7:0] value;
      pin(1'b1, 1'b0, 1'($urandom));
      pin(1'b0, 1'b0, 1'($urandom));
      for (b = 0; b < n_bytes; b++) begin
         value = (b == 0) ? addr : 8'($urandom);
         nbits = (b == n_bytes - 1 && cut_bits >= 0) ? cut_bits : 8;
         send_byte(value, nbits);
      end
      pin(1'b0, 1'b0, 1'($urandom));
      pin(1'b1, 1'b0, 1'($urandom));
   endtask

   function automatic logic [7:0] pick_addr();
      case ($urandom_range(0, 9))
         0, 1, 2: return ADDR_DEVICE_ID;
         3, 4:    return ADDR_TEMP;
         5, 6:    return ADDR_PRES;
         7:       return 8'hFD + 8'($urandom_range(0, 2));
         8:       return 8'($urandom);
         default: return ADDR_PRES + 8'd1;
      endcase
   endfunction

   task automatic test_unselected_pins();
      pin(1'b1, 1'b0, 1'b0);
      pin(1'b1, 1'b1, 1'b1);
      pin(1'b1, 1'b0, 1'b1);
      pin(1'b1, 1'b1, 1'b0);
      pin(1'b1, 1'b0, 1'b0);
   endtask

   task automatic test_address_byte();
      pin(1'b0, 1'b0, 1'b1);
      send_byte(ADDR_TEMP, 8);
      pin(1'b0, 1'b0, 1'b0);
      pin(1'b1, 1'b0, 1'b0);
   endtask

   task automatic test_device_id_settings();
      logic [7:0] id_list[4];
      int k;
      id_list = '{8'h00, 8'hFF, 8'($urandom), DEVICE_ID_RESET};
      spi_frame(ADDR_DEVICE_ID, 2, -1);
      for (k = 0; k < 4; k++) begin
         write_device_id(id_list[k]);
         spi_frame(ADDR_DEVICE_ID, 2, -1);
         spi_frame(8'hFF, 3, -1);
      end
   endtask

   task automatic test_address_wrap();
      int k;
      for (k = 0; k < 3; k++) begin
         spi_frame(8'hFD + 8'(k), $urandom_range(4, 6), -1);
      end
   endtask

   task automatic test_backpressure();
      hold_go = 1'b1;
      spi_frame(ADDR_PRES, 2, -1);
   endtask

   task automatic test_random_frames();
      int kind;
      while (items_sent < 1050) begin
         kind = $urandom_range(0, 19);
         if (kind < 15) begin
            spi_frame(pick_addr(), $urandom_range(1, 4), -1);
         end else if (kind < 17) begin
            spi_frame(pick_addr(), $urandom_range(1, 3), $urandom_range(0, 7));
         end else if (kind < 19) begin
            repeat ($urandom_range(4, 16)) pin(1'($urandom), 1'($urandom), 1'($urandom));
         end else begin
            write_device_id(8'($urandom));
         end
      end
   endtask

   task automatic test_steady_stream();
      idle_enable = 1'b0;
      while (items_sent < 1150) begin
         spi_frame(pick_addr(), $urandom_range(1, 3), -1);
      end
   endtask

   initial begin : rsp_stall_driver
      int n;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_stall <= 1'b0;
         end else if (hold_go) begin
            hold_go = 1'b0;
            rsp_stall <= 1'b1;
            for (n = 1; n < LONG_HOLD; n++) @(posedge clock);
         end else if (idle_enable && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(0, 5)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      logic exp_bit;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (miso_expected.size() == 0) begin
            $display("%0t: miso transfer with none expected, expected none, actual %0b",
                     $time, rsp_miso_bit);
            error_count++;
         end else begin
            exp_bit = miso_expected.pop_front();
            if (rsp_miso_bit !== exp_bit) begin
               $display("%0t: miso mismatch, expected %0b, actual %0b",
                        $time, exp_bit, rsp_miso_bit);
               error_count++;
            end
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_unselected_pins();
      test_address_byte();
      test_device_id_settings();
      test_address_wrap();
      test_backpressure();
      test_random_frames();
      test_steady_stream();
      req_valid <= 1'b0;
      wait (miso_expected.size() == 0);
      repeat (8) @(posedge clock);
      if (error_count == 0 && miso_expected.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/ssrs_pkg.sv
hw/rtl/spi_sensor_register_slave_core.sv
hw/rtl/ssrs_checker.sv
tb/tb.sv
